[rtl/core/fbpc_pkg.sv]
// shared types and constants of the frustum box and point culling block
`timescale 1ns / 1ps
`default_nettype none

package fbpc_pkg;

	// port widths of the stream channels
	localparam int FIELD_W   = 32;
	localparam int S_TDATA_W = 4 * FIELD_W;
	localparam int S_TUSER_W = 5;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 1;

	// arithmetic widths
	localparam int ACC_W = 64;
	localparam int MUL_W = 33;

	localparam logic signed [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// last axis number of a box
	localparam logic [2:0] AXIS_LAST = 3'd2;

	// item function codes
	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_POINT  = 2'd1,
		FUNC_CENTER = 2'd2,
		FUNC_AXIS   = 2'd3
	} func_t;

	// step codes of the shared multiply and add unit
	typedef enum logic [3:0] {
		OP_MUL_AX    = 4'd0,
		OP_MUL_BY    = 4'd1,
		OP_MUL_CZ    = 4'd2,
		OP_LOAD_D    = 4'd3,
		OP_ADD_LAST  = 4'd4,
		OP_POINT_CHK = 4'd5,
		OP_CENTER    = 4'd6,
		OP_MUL_LO    = 4'd7,
		OP_MUL_HI    = 4'd8,
		OP_COMBINE   = 4'd9,
		OP_ACCUM     = 4'd10,
		OP_BOX_CHK   = 4'd11
	} op_t;

	// job handed from the input side to the sequencer
	typedef struct packed {
		logic  go;
		func_t func;
		logic  last_axis;
	} job_t;

	// step control from the sequencer to the unit
	typedef struct packed {
		logic active;
		logic init;
		op_t  op;
	} ctrl_t;

	// sequencer status toward the ports
	typedef struct packed {
		logic idle;
		logic load;
	} seq_stat_t;

endpackage

`default_nettype wire

[rtl/core/fbpc_seq.sv]
// step sequencer that walks the planes through the shared arithmetic unit
`timescale 1ns / 1ps
`default_nettype none

module fbpc_seq #(
	parameter int PLANE_COUNT = 6,
	parameter int PIDX_W      = 3
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire fbpc_pkg::job_t     job,
	input  wire                     out_free,
	output fbpc_pkg::ctrl_t         ctrl,
	output logic [PIDX_W-1:0]       pidx,
	output fbpc_pkg::seq_stat_t     stat
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                state_q;
	fbpc_pkg::op_t         op_q;
	fbpc_pkg::func_t       func_q;
	logic                  last_q;
	logic [PIDX_W-1:0]     pidx_q;
	logic                  plane_last;

	assign plane_last = (pidx_q == PIDX_W'(PLANE_COUNT - 1));

	// step and plane sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= fbpc_pkg::OP_MUL_AX;
			func_q  <= fbpc_pkg::FUNC_LOAD;
			last_q  <= 1'b0;
			pidx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job.go) begin
						state_q <= ST_RUN;
						op_q    <= fbpc_pkg::OP_MUL_AX;
						func_q  <= job.func;
						last_q  <= job.last_axis;
						pidx_q  <= '0;
					end
				end
				ST_RUN: begin
					case (op_q)
						fbpc_pkg::OP_MUL_AX: op_q <= fbpc_pkg::OP_MUL_BY;
						fbpc_pkg::OP_MUL_BY: op_q <= fbpc_pkg::OP_MUL_CZ;
						fbpc_pkg::OP_MUL_CZ: begin
							op_q <= (func_q == fbpc_pkg::FUNC_AXIS) ?
								fbpc_pkg::OP_ADD_LAST : fbpc_pkg::OP_LOAD_D;
						end
						fbpc_pkg::OP_LOAD_D: op_q <= fbpc_pkg::OP_ADD_LAST;
						fbpc_pkg::OP_ADD_LAST: begin
							case (func_q)
								fbpc_pkg::FUNC_POINT:  op_q <= fbpc_pkg::OP_POINT_CHK;
								fbpc_pkg::FUNC_CENTER: op_q <= fbpc_pkg::OP_CENTER;
								default:               op_q <= fbpc_pkg::OP_MUL_LO;
							endcase
						end
						fbpc_pkg::OP_MUL_LO:  op_q <= fbpc_pkg::OP_MUL_HI;
						fbpc_pkg::OP_MUL_HI:  op_q <= fbpc_pkg::OP_COMBINE;
						fbpc_pkg::OP_COMBINE: op_q <= fbpc_pkg::OP_ACCUM;
						fbpc_pkg::OP_POINT_CHK,
						fbpc_pkg::OP_CENTER,
						fbpc_pkg::OP_ACCUM: begin
							// end of one plane
							if (!plane_last) begin
								pidx_q <= pidx_q + PIDX_W'(1);
								op_q   <= fbpc_pkg::OP_MUL_AX;
							end else if (op_q == fbpc_pkg::OP_POINT_CHK) begin
								state_q <= ST_DONE;
							end else if (op_q == fbpc_pkg::OP_ACCUM && last_q) begin
								pidx_q <= '0;
								op_q   <= fbpc_pkg::OP_BOX_CHK;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						fbpc_pkg::OP_BOX_CHK: begin
							if (plane_last) begin
								state_q <= ST_DONE;
							end else begin
								pidx_q <= pidx_q + PIDX_W'(1);
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign ctrl.active = (state_q == ST_RUN);
	assign ctrl.init   = job.go && (state_q == ST_IDLE);
	assign ctrl.op     = op_q;
	assign pidx        = pidx_q;
	assign stat.idle   = (state_q == ST_IDLE);
	assign stat.load   = (state_q == ST_DONE) && out_free;

endmodule

`default_nettype wire

[rtl/core/fbpc_unit.sv]
// shared multiplier and saturating adder with the per plane distance and spread sums
`timescale 1ns / 1ps
`default_nettype none

module fbpc_unit #(
	parameter int PLANE_COUNT = 6,
	parameter int COORD_WIDTH = 32,
	parameter int PIDX_W      = 3
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire fbpc_pkg::ctrl_t           ctrl,
	input  wire [PIDX_W-1:0]               pidx,
	input  wire signed [COORD_WIDTH-1:0]   coef_a,
	input  wire signed [COORD_WIDTH-1:0]   coef_b,
	input  wire signed [COORD_WIDTH-1:0]   coef_c,
	input  wire signed [COORD_WIDTH-1:0]   coef_d,
	input  wire signed [COORD_WIDTH-1:0]   vx,
	input  wire signed [COORD_WIDTH-1:0]   vy,
	input  wire signed [COORD_WIDTH-1:0]   vz,
	input  wire [COORD_WIDTH-1:0]          ext,
	output logic                           in_frustum
);

	localparam int AW = fbpc_pkg::ACC_W;
	localparam int MW = fbpc_pkg::MUL_W;

	logic signed [AW-1:0]   prod_q;
	logic signed [AW-1:0]   acc_q;
	logic signed [AW-1:0]   center_q [PLANE_COUNT];
	logic signed [AW-1:0]   spread_q [PLANE_COUNT];
	logic                   inside_q;

	logic [AW-1:0]          mag;
	logic signed [MW-1:0]   mul_a;
	logic signed [MW-1:0]   mul_b;
	logic signed [2*MW-1:0] mul_full;
	logic signed [AW-1:0]   d_shift;
	logic signed [AW-1:0]   add_a;
	logic signed [AW-1:0]   add_b;
	logic [AW:0]            sum;
	logic signed [AW-1:0]   sum_sat;
	logic                   hi_ovf;

	// magnitude of the dot product held in the accumulator
	assign mag = {AW{1'b0}} - $unsigned(acc_q);

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.op)
			fbpc_pkg::OP_MUL_AX: begin
				mul_a = {{(MW-COORD_WIDTH){coef_a[COORD_WIDTH-1]}}, coef_a};
				mul_b = {{(MW-COORD_WIDTH){vx[COORD_WIDTH-1]}}, vx};
			end
			fbpc_pkg::OP_MUL_BY: begin
				mul_a = {{(MW-COORD_WIDTH){coef_b[COORD_WIDTH-1]}}, coef_b};
				mul_b = {{(MW-COORD_WIDTH){vy[COORD_WIDTH-1]}}, vy};
			end
			fbpc_pkg::OP_MUL_CZ: begin
				mul_a = {{(MW-COORD_WIDTH){coef_c[COORD_WIDTH-1]}}, coef_c};
				mul_b = {{(MW-COORD_WIDTH){vz[COORD_WIDTH-1]}}, vz};
			end
			fbpc_pkg::OP_MUL_LO: begin
				mul_a = {1'b0, (acc_q[AW-1] ? mag[31:0] : acc_q[31:0])};
				mul_b = {{(MW-COORD_WIDTH){1'b0}}, ext};
			end
			fbpc_pkg::OP_MUL_HI: begin
				mul_a = {1'b0, (acc_q[AW-1] ? mag[63:32] : acc_q[63:32])};
				mul_b = {{(MW-COORD_WIDTH){1'b0}}, ext};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// plane offset d scaled to the product format
	assign d_shift = {{(AW-16-COORD_WIDTH){coef_d[COORD_WIDTH-1]}}, coef_d, 16'h0000};

	// high partial product beyond the representable spread
	assign hi_ovf = (prod_q[AW-1:47] != '0);

	// adder operand selection
	always_comb begin
		case (ctrl.op)
			fbpc_pkg::OP_COMBINE: begin
				add_a = {prod_q[47:0], 16'h0000};
				add_b = acc_q;
			end
			fbpc_pkg::OP_ACCUM: begin
				add_a = spread_q[pidx];
				add_b = acc_q;
			end
			fbpc_pkg::OP_BOX_CHK: begin
				add_a = center_q[pidx];
				add_b = spread_q[pidx];
			end
			default: begin
				add_a = acc_q;
				add_b = prod_q;
			end
		endcase
	end

	// shared 65 bit adder with saturation to 64 bits
	assign sum = {add_a[AW-1], add_a} + {add_b[AW-1], add_b};
	assign sum_sat = (sum[AW] != sum[AW-1]) ?
		(sum[AW] ? fbpc_pkg::SAT_MIN : fbpc_pkg::SAT_MAX) : sum[AW-1:0];

	// product and accumulator registers
	always_ff @(posedge clk) begin
		if (ctrl.active) begin
			case (ctrl.op)
				fbpc_pkg::OP_MUL_AX: begin
					prod_q <= mul_full[AW-1:0];
				end
				fbpc_pkg::OP_MUL_BY: begin
					prod_q <= mul_full[AW-1:0];
					acc_q  <= prod_q;
				end
				fbpc_pkg::OP_MUL_CZ: begin
					prod_q <= mul_full[AW-1:0];
					acc_q  <= sum_sat;
				end
				fbpc_pkg::OP_LOAD_D: begin
					prod_q <= d_shift;
					acc_q  <= sum_sat;
				end
				fbpc_pkg::OP_ADD_LAST: begin
					acc_q <= sum_sat;
				end
				fbpc_pkg::OP_MUL_LO: begin
					prod_q <= mul_full[AW-1:0];
				end
				fbpc_pkg::OP_MUL_HI: begin
					prod_q <= mul_full[AW-1:0];
					acc_q  <= {16'h0000, prod_q[AW-1:16]};
				end
				fbpc_pkg::OP_COMBINE: begin
					acc_q <= hi_ovf ? fbpc_pkg::SAT_MAX : sum_sat;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	// per plane center distances, spread sums and the inside flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				center_q[i] <= '0;
				spread_q[i] <= '0;
			end
			inside_q <= 1'b1;
		end else if (ctrl.init) begin
			inside_q <= 1'b1;
		end else if (ctrl.active) begin
			case (ctrl.op)
				fbpc_pkg::OP_CENTER: begin
					center_q[pidx] <= acc_q;
					spread_q[pidx] <= '0;
				end
				fbpc_pkg::OP_ACCUM: begin
					spread_q[pidx] <= sum_sat;
				end
				fbpc_pkg::OP_POINT_CHK: begin
					if (acc_q[AW-1]) begin
						inside_q <= 1'b0;
					end
				end
				fbpc_pkg::OP_BOX_CHK: begin
					if (sum[AW]) begin
						inside_q <= 1'b0;
					end
				end
				default: begin
					inside_q <= inside_q;
				end
			endcase
		end
	end

	assign in_frustum = inside_q;

endmodule

`default_nettype wire

[rtl/core/frustum_box_point_cull.sv]
// top level of the frustum culling block for points and oriented boxes
//
// Items enter on the s_ stream: tuser carries the function and the slot, tdata the
// four Q16.16 words. A plane load writes the plane store in the cycle it is accepted
// and leaves s_tready high, as does an axis item past the last axis. Every other item
// is walked plane by plane through one shared multiplier and one saturating 64 bit
// adder, and s_tready stays low until that walk ends:
//   point test      per plane a*x, b*y, c*z, d, sum, sign check; result on m_tvalid
//   box center      per plane a*x, b*y, c*z, d, sum, stored as center; no result
//   box axis 0, 1   per plane dot, |dot| * |w| low and high, spread sum; no result
//   box axis 2      as axis 0, 1, then center plus spread sign check; result on m_tvalid
// A walk with a result ends as the result moves into the output register, so s_tready
// rises together with m_tvalid and the next item can go in on the following edge.
// Results leave on the m_ stream from that register: inside in tdata, the kind of test
// in tuser. While the receiver stalls, a following item is still taken and worked on;
// its finished result then waits in the unit, with the sequencer done and s_tready low,
// until the register is free.
// Reset clears the plane store, the center distances and the spread sums, so every
// unloaded plane counts as inside.
`timescale 1ns / 1ps
`default_nettype none

module frustum_box_point_cull #(
	parameter int PLANE_COUNT = 6,
	parameter int COORD_WIDTH = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// vec_x, vec_y, vec_z, vec_w
	input  wire [fbpc_pkg::S_TDATA_W-1:0]       s_tdata,
	// func, slot
	input  wire [fbpc_pkg::S_TUSER_W-1:0]       s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// inside_res, zero fill
	output logic [fbpc_pkg::M_TDATA_W-1:0]      m_tdata,
	// test_kind
	output logic [fbpc_pkg::M_TUSER_W-1:0]      m_tuser
);

	localparam int PIDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
	localparam int FW     = fbpc_pkg::FIELD_W;

	logic signed [COORD_WIDTH-1:0] coef_q [PLANE_COUNT][4];
	logic signed [COORD_WIDTH-1:0] vx_q;
	logic signed [COORD_WIDTH-1:0] vy_q;
	logic signed [COORD_WIDTH-1:0] vz_q;
	logic [COORD_WIDTH-1:0]        ext_q;
	logic                          kind_q;
	logic                          m_tvalid_q;
	logic                          res_q;
	logic                          res_kind_q;

	fbpc_pkg::func_t               in_func;
	logic [2:0]                    in_slot;
	logic signed [COORD_WIDTH-1:0] in_w;
	logic                          s_accept;
	logic                          skip;
	fbpc_pkg::job_t                job;
	fbpc_pkg::ctrl_t               ctrl;
	fbpc_pkg::seq_stat_t           stat;
	logic [PIDX_W-1:0]             pidx;
	logic                          out_free;
	logic                          in_frustum;

	assign in_func  = fbpc_pkg::func_t'(s_tuser[1:0]);
	assign in_slot  = s_tuser[4:2];
	assign in_w     = s_tdata[3*FW +: COORD_WIDTH];
	assign s_tready = stat.idle;
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// loads and axis items past the last axis start no walk
	assign skip = (in_func == fbpc_pkg::FUNC_LOAD) ||
		((in_func == fbpc_pkg::FUNC_AXIS) && (in_slot > fbpc_pkg::AXIS_LAST));

	assign job.go        = s_accept && !skip;
	assign job.func      = in_func;
	assign job.last_axis = (in_slot == fbpc_pkg::AXIS_LAST);

	// plane store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				for (int k = 0; k < 4; k++) begin
					coef_q[p][k] <= '0;
				end
			end
		end else if (s_accept && (in_func == fbpc_pkg::FUNC_LOAD) &&
			({1'b0, in_slot} < 4'(PLANE_COUNT))) begin
			for (int k = 0; k < 4; k++) begin
				coef_q[in_slot[PIDX_W-1:0]][k] <= s_tdata[k*FW +: COORD_WIDTH];
			end
		end
	end

	// item capture for the walk
	always_ff @(posedge clk) begin
		if (job.go) begin
			vx_q   <= s_tdata[0*FW +: COORD_WIDTH];
			vy_q   <= s_tdata[1*FW +: COORD_WIDTH];
			vz_q   <= s_tdata[2*FW +: COORD_WIDTH];
			ext_q  <= in_w[COORD_WIDTH-1] ? (~in_w + COORD_WIDTH'(1)) : in_w;
			kind_q <= (in_func != fbpc_pkg::FUNC_POINT);
		end
	end

	fbpc_seq #(
		.PLANE_COUNT (PLANE_COUNT),
		.PIDX_W      (PIDX_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.out_free (out_free),
		.ctrl     (ctrl),
		.pidx     (pidx),
		.stat     (stat)
	);

	fbpc_unit #(
		.PLANE_COUNT (PLANE_COUNT),
		.COORD_WIDTH (COORD_WIDTH),
		.PIDX_W      (PIDX_W)
	) u_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.pidx       (pidx),
		.coef_a     (coef_q[pidx][0]),
		.coef_b     (coef_q[pidx][1]),
		.coef_c     (coef_q[pidx][2]),
		.coef_d     (coef_q[pidx][3]),
		.vx         (vx_q),
		.vy         (vy_q),
		.vz         (vz_q),
		.ext        (ext_q),
		.in_frustum (in_frustum)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (stat.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result and its kind held together while the receiver stalls
	always_ff @(posedge clk) begin
		if (stat.load) begin
			res_q      <= in_frustum;
			res_kind_q <= kind_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(fbpc_pkg::M_TDATA_W-1){1'b0}}, res_q};
	assign m_tuser  = res_kind_q;

	// a point test always occupies the sequencer after acceptance
	a_point_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && in_func == fbpc_pkg::FUNC_POINT) |=> !s_tready)
		else $error("point test accepted without starting a walk");

	// a plane load never blocks the input
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && in_func == fbpc_pkg::FUNC_LOAD) |=> s_tready)
		else $error("plane load stalled the input");

	// a new result only comes out of a finished walk
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a walk");

endmodule

`default_nettype wire

[tb/sv/tb_frustum_box_point_cull.sv]
// testbench of the frustum box and point culling block: directed table, random items, predictor
`timescale 1ns / 1ps

module tb_frustum_box_point_cull;

	localparam int PLANES     = 6;
	localparam int SETTLE_CYC = 9 * PLANES + 2 + 24;
	localparam int HOLD_CYC   = 400;

	localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] Q_TWO  = 32'sh0002_0000;
	localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
	localparam logic signed [31:0] C_MIN  = 32'sh8000_0000;
	localparam logic signed [31:0] C_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] C_ZERO = 32'sh0000_0000;

	typedef logic signed [fbpc_pkg::ACC_W-1:0] acc_t;

	// how a directed row gets its expected result
	typedef enum bit {
		CHK_PRED  = 1'b0,
		CHK_TYPED = 1'b1
	} check_t;

	typedef struct {
		fbpc_pkg::func_t    func;
		logic [2:0]         slot;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
	} cull_item_t;

	typedef struct {
		logic is_in;
		logic kind;
	} cull_verdict_t;

	typedef struct {
		fbpc_pkg::func_t    func;
		logic [2:0]         slot;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		check_t             chk;
		logic               is_in;
		logic               kind;
	} dir_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [fbpc_pkg::S_TDATA_W-1:0] s_tdata;
	logic [fbpc_pkg::S_TUSER_W-1:0] s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [fbpc_pkg::M_TDATA_W-1:0] m_tdata;
	logic [fbpc_pkg::M_TUSER_W-1:0] m_tuser;

	// predictor state
	logic [31:0] plane_word [0:4*PLANES-1];
	acc_t        ctr_dist   [0:PLANES-1];
	acc_t        spread_acc [0:PLANES-1];

	cull_verdict_t verdict_q [$];
	int            err_cnt    = 0;
	bit            tx_idle_on = 1'b1;
	bit            rx_idle_on = 1'b1;
	bit            hold_req   = 1'b0;

	// directed stimulus, walked in order from reset
	dir_row_t dir_table [25] = '{
		// empty plane store: every test is inside
		'{fbpc_pkg::FUNC_POINT, 3'd0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, CHK_TYPED, 1'b1, 1'b0},
		'{fbpc_pkg::FUNC_POINT, 3'd7, C_MIN, C_MAX, C_MIN, C_MAX, CHK_TYPED, 1'b1, 1'b0},
		'{fbpc_pkg::FUNC_CENTER, 3'd0, C_MAX, C_MIN, C_MAX, C_MIN, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_AXIS, 3'd0, Q_ONE, C_ZERO, C_ZERO, Q_ONE, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_AXIS, 3'd1, C_ZERO, Q_ONE, C_ZERO, C_MIN, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_AXIS, 3'd2, C_ZERO, C_ZERO, Q_ONE, C_MAX, CHK_TYPED, 1'b1, 1'b1},
		// half space x >= 0, loads past the last plane are dropped
		'{fbpc_pkg::FUNC_LOAD, 3'd0, Q_ONE, C_ZERO, C_ZERO, C_ZERO, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_LOAD, 3'd6, C_MIN, C_MIN, C_MIN, C_MIN, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_LOAD, 3'd7, C_MAX, C_MAX, C_MAX, C_MAX, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_POINT, 3'd0, -32'sd1, C_ZERO, C_ZERO, C_ZERO, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_POINT, 3'd0, C_ZERO, C_MAX, C_MIN, C_ZERO, CHK_PRED, 1'b0, 1'b0},
		// extreme coefficients drive the sums into saturation
		'{fbpc_pkg::FUNC_LOAD, 3'd1, C_MIN, C_MIN, C_MIN, C_MIN, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_POINT, 3'd0, C_MIN, C_MIN, C_MIN, C_ZERO, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_LOAD, 3'd2, C_MAX, C_MAX, C_MAX, C_MAX, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_LOAD, 3'd5, C_ZERO, C_ZERO, Q_ONE, Q_TWO, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_POINT, 3'd0, Q_ONE, C_MAX, C_MAX, C_ZERO, CHK_PRED, 1'b0, 1'b0},
		// box with ignored axis numbers mixed in
		'{fbpc_pkg::FUNC_CENTER, 3'd0, -Q_HALF, C_ZERO, C_ZERO, C_ZERO, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_AXIS, 3'd3, C_MAX, C_MAX, C_MAX, C_MAX, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_AXIS, 3'd0, Q_ONE, C_ZERO, C_ZERO, Q_ONE, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_AXIS, 3'd7, C_MIN, C_MIN, C_MIN, C_MIN, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_AXIS, 3'd1, C_ZERO, Q_ONE, C_ZERO, C_MIN, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_AXIS, 3'd2, C_ZERO, C_ZERO, Q_ONE, -Q_ONE, CHK_PRED, 1'b0, 1'b0},
		// last axis with no center in front of it
		'{fbpc_pkg::FUNC_AXIS, 3'd2, C_MIN, C_MIN, C_MIN, C_MIN, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_LOAD, 3'd4, C_ZERO, C_ZERO, C_ZERO, C_MIN, CHK_PRED, 1'b0, 1'b0},
		'{fbpc_pkg::FUNC_POINT, 3'd0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, CHK_PRED, 1'b0, 1'b0}
	};

	frustum_box_point_cull #(
		.PLANE_COUNT(PLANES),
		.COORD_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// saturating 64 bit add
	function automatic acc_t sat_sum(acc_t a, acc_t b);
		logic signed [fbpc_pkg::ACC_W:0] s;
		s = $signed({a[fbpc_pkg::ACC_W-1], a}) + $signed({b[fbpc_pkg::ACC_W-1], b});
		if (s[fbpc_pkg::ACC_W] != s[fbpc_pkg::ACC_W-1]) begin
			return s[fbpc_pkg::ACC_W] ? fbpc_pkg::SAT_MIN : fbpc_pkg::SAT_MAX;
		end
		return s[fbpc_pkg::ACC_W-1:0];
	endfunction

	// normal dot vector, plus d scaled to Q32.32 when asked
	function automatic acc_t plane_distance(int p, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, bit with_d);
		acc_t s;
		s = acc_t'($signed(plane_word[4*p])) * acc_t'(x);
		s = sat_sum(s, acc_t'($signed(plane_word[4*p+1])) * acc_t'(y));
		s = sat_sum(s, acc_t'($signed(plane_word[4*p+2])) * acc_t'(z));
		if (with_d) begin
			s = sat_sum(s, acc_t'($signed(plane_word[4*p+3])) * acc_t'(65536));
		end
		return s;
	endfunction

	// |dot| times |extent|, back to Q32.32, clamped to the positive limit
	function automatic acc_t spread_part(acc_t dot, logic [31:0] ext_mag);
		logic [63:0] m;
		logic [63:0] e;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] r;
		m  = dot[63] ? (~dot + 64'd1) : dot;
		e  = {32'd0, ext_mag};
		hi = (m >> 32) * e;
		lo = ((m & 64'h0000_0000_FFFF_FFFF) * e) >> 16;
		if (hi >= 64'h0000_8000_0000_0000) begin
			return fbpc_pkg::SAT_MAX;
		end
		r = (hi << 16) + lo;
		if (r > 64'h7FFF_FFFF_FFFF_FFFF) begin
			return fbpc_pkg::SAT_MAX;
		end
		return acc_t'(r);
	endfunction

	// culling predictor: updates its state and gives the result, if any
	task automatic cull_predict(input cull_item_t it, output bit has_res,
			output cull_verdict_t v);
		logic [31:0] ext_mag;
		bit          ok;
		int          base;
		has_res = 1'b0;
		v       = '{is_in: 1'b0, kind: 1'b0};
		ok      = 1'b1;
		base    = 4 * it.slot;
		case (it.func)
			fbpc_pkg::FUNC_LOAD: begin
				if (it.slot < PLANES) begin
					plane_word[base]   = it.x;
					plane_word[base+1] = it.y;
					plane_word[base+2] = it.z;
					plane_word[base+3] = it.w;
				end
			end
			fbpc_pkg::FUNC_POINT: begin
				for (int p = 0; p < PLANES; p++) begin
					if (plane_distance(p, it.x, it.y, it.z, 1'b1) < 0) ok = 1'b0;
				end
				has_res = 1'b1;
				v       = '{is_in: ok, kind: 1'b0};
			end
			fbpc_pkg::FUNC_CENTER: begin
				for (int p = 0; p < PLANES; p++) begin
					ctr_dist[p]   = plane_distance(p, it.x, it.y, it.z, 1'b1);
					spread_acc[p] = '0;
				end
			end
			default: begin
				if (it.slot <= fbpc_pkg::AXIS_LAST) begin
					ext_mag = it.w[31] ? 32'(-it.w) : 32'(it.w);
					for (int p = 0; p < PLANES; p++) begin
						spread_acc[p] = sat_sum(spread_acc[p], spread_part(
							plane_distance(p, it.x, it.y, it.z, 1'b0), ext_mag));
					end
					if (it.slot == fbpc_pkg::AXIS_LAST) begin
						for (int p = 0; p < PLANES; p++) begin
							if (ctr_dist[p] < -spread_acc[p]) ok = 1'b0;
						end
						has_res = 1'b1;
						v       = '{is_in: ok, kind: 1'b1};
					end
				end
			end
		endcase
	endtask

	// offer one item at a falling edge, predict at the accepting rising edge
	task automatic push_item(input cull_item_t it, input bit typed,
			input cull_verdict_t typed_v);
		bit            has_res;
		cull_verdict_t v;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {it.w, it.z, it.y, it.x};
		s_tuser  = {it.slot, it.func};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		cull_predict(it, has_res, v);
		if (has_res) verdict_q.push_back(typed ? typed_v : v);
		@(negedge clk);
	endtask

	task automatic send_item(fbpc_pkg::func_t func, logic [2:0] slot,
			logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
			logic signed [31:0] w);
		cull_item_t it;
		it = '{func: func, slot: slot, x: x, y: y, z: z, w: w};
		push_item(it, 1'b0, '{is_in: 1'b0, kind: 1'b0});
	endtask

	// wait until every result is back and the block has gone quiet
	task automatic drain();
		s_tvalid = 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// mostly small values so tests land on both sides, sometimes full range
	function automatic logic signed [31:0] rand_coord(int span);
		int v;
		case ($urandom_range(0, 15))
			0:       return $urandom;
			1:       return C_MIN;
			2:       return C_MAX;
			3:       return C_ZERO;
			default: begin
				v = int'($urandom_range(0, 2 * span)) - span;
				return v;
			end
		endcase
	endfunction

	// random traffic: plane loads, point tests, box runs, some noise
	task automatic run_random(int n_items);
		int                 sent;
		int                 r;
		int                 stop_at;
		logic signed [31:0] d;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				if ($urandom_range(0, 7) == 0) begin
					send_item(fbpc_pkg::FUNC_LOAD, 3'($urandom_range(6, 7)), $urandom,
						$urandom, $urandom, $urandom);
				end else begin
					d = rand_coord(8 * Q_ONE);
					if ($urandom_range(0, 2) == 0 && d < 0) d = -d;
					send_item(fbpc_pkg::FUNC_LOAD, 3'($urandom_range(0, PLANES - 1)),
						rand_coord(Q_ONE), rand_coord(Q_ONE), rand_coord(Q_ONE), d);
					sent++;
				end
			end else if (r < 45) begin
				send_item(fbpc_pkg::FUNC_POINT, 3'($urandom), rand_coord(4 * Q_ONE),
					rand_coord(4 * Q_ONE), rand_coord(4 * Q_ONE), $urandom);
				sent++;
			end else if (r < 92) begin
				// box run; some runs lose the center or stop early
				if ($urandom_range(0, 9) != 0) begin
					send_item(fbpc_pkg::FUNC_CENTER, 3'($urandom), rand_coord(4 * Q_ONE),
						rand_coord(4 * Q_ONE), rand_coord(4 * Q_ONE), $urandom);
					sent++;
				end
				stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2;
				for (int a = 0; a <= stop_at; a++) begin
					if ($urandom_range(0, 9) == 0) begin
						send_item(fbpc_pkg::FUNC_AXIS, 3'($urandom_range(3, 7)), $urandom,
							$urandom, $urandom, $urandom);
					end
					send_item(fbpc_pkg::FUNC_AXIS, 3'(a), rand_coord(Q_ONE),
						rand_coord(Q_ONE), rand_coord(Q_ONE), rand_coord(2 * Q_ONE));
					sent++;
				end
			end else begin
				send_item(fbpc_pkg::func_t'($urandom_range(1, 3)), 3'($urandom), $urandom,
					$urandom, $urandom, $urandom);
				sent++;
			end
		end
	endtask

	// receiver: random stalls, and one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYC - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		cull_verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$error("result transaction with none predicted: inside_res %0d test_kind %0d",
					m_tdata[0], m_tuser[0]);
				err_cnt++;
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[0] !== want.is_in) begin
					$error("inside_res: expected %0d, actual %0d", want.is_in, m_tdata[0]);
					err_cnt++;
				end
				if (m_tuser[0] !== want.kind) begin
					$error("test_kind: expected %0d, actual %0d", want.kind, m_tuser[0]);
					err_cnt++;
				end
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("frustum_box_point_cull test failed");
		$finish;
	end

	// main sequence
	initial begin : main_seq
		cull_item_t    it;
		cull_verdict_t tv;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		for (int i = 0; i < 4 * PLANES; i++) plane_word[i] = '0;
		for (int p = 0; p < PLANES; p++) begin
			ctr_dist[p]   = '0;
			spread_acc[p] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (dir_table[i]) begin
			it = '{func: dir_table[i].func, slot: dir_table[i].slot, x: dir_table[i].x,
				y: dir_table[i].y, z: dir_table[i].z, w: dir_table[i].w};
			tv = '{is_in: dir_table[i].is_in, kind: dir_table[i].kind};
			push_item(it, dir_table[i].chk == CHK_TYPED, tv);
		end
		drain();

		run_random(170);

		// long receiver hold-off while point tests keep coming
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++) begin
			send_item(fbpc_pkg::FUNC_POINT, 3'($urandom), rand_coord(4 * Q_ONE),
				rand_coord(4 * Q_ONE), rand_coord(4 * Q_ONE), $urandom);
		end
		drain();

		run_random(150);

		// closing stretch with no idling on either side
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_random(60);
		drain();

		if (err_cnt == 0) begin
			$display("frustum_box_point_cull test passed");
		end else begin
			$display("frustum_box_point_cull test failed");
		end
		$finish;
	end

endmodule

[frustum_box_point_cull.f]
rtl/core/fbpc_pkg.sv
rtl/core/fbpc_seq.sv
rtl/core/fbpc_unit.sv
rtl/core/frustum_box_point_cull.sv
tb/sv/tb_frustum_box_point_cull.sv
